[src/rhsf_pkg.sv]
// Shared types and constants for the rolling-hash substring finder.
`timescale 1ns / 1ps
`default_nettype none
package rhsf_pkg;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_MAX_TEXT    = 65536;
  localparam int DEF_HASH_BITS   = 32;

  localparam int POS_W   = 16;
  localparam int Q_DEPTH = 4;

  localparam logic [7:0] CHAR_OFFSET = 8'd97;

  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NO_PATTERN = 2'd2;
  localparam logic [1:0] ST_TEXT_LONG  = 2'd3;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             restart;
    logic             load;
    logic             active;
    logic             full;
    logic             fin;
    logic             err;
    logic [1:0]       err_status;
    logic [POS_W-1:0] pos;
  } ctl_t;

endpackage
`default_nettype wire

[src/rolling_hash_substring_finder_core.sv]
// Result path: the final text byte passes the input register, the queue and the
//   result register before its result is on out_*; a full queue and out_stall can hold it.
// Throughput: one pattern or text byte per cycle while in_stall is low, set by the
//   combinational window hash update (hash * 26 + term) in the back end.
// Reset: rst_n synchronous, active low; clears pattern, text and match state.
//   The window byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module rolling_hash_substring_finder_core #(
  parameter int MAX_PATTERN = rhsf_pkg::DEF_MAX_PATTERN,
  parameter int MAX_TEXT    = rhsf_pkg::DEF_MAX_TEXT,
  parameter int HASH_BITS   = rhsf_pkg::DEF_HASH_BITS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_req_type,
  input  wire  [7:0]  in_char_value,
  input  wire         in_last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_position
);
  import rhsf_pkg::*;

  logic                 push, pop, q_full, head_valid;
  ctl_t                 push_ctl, head_ctl;
  logic [HASH_BITS-1:0] push_term, head_term;

  rhsf_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT),
    .HASH_BITS   (HASH_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_char_value (in_char_value),
    .in_last       (in_last),
    .q_full        (q_full),
    .push          (push),
    .push_ctl      (push_ctl),
    .push_term     (push_term)
  );

  rhsf_queue #(
    .HASH_BITS (HASH_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_term  (push_term),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_term  (head_term)
  );

  rhsf_back #(
    .HASH_BITS (HASH_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_ctl     (head_ctl),
    .head_term    (head_term),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position)
  );

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_FOUND) |-> (out_position == '0))
    else $error("position not zero on a non-found result");

  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_ctl.op == OP_TEXT && head_ctl.fin) |-> (!out_valid || !out_stall))
    else $error("final request retired while result slot is occupied");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !pop) |=> !out_valid)
    else $error("result repeated after being taken");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[src/rhsf_front.sv]
// Front end: request intake, pattern/text bookkeeping, window store and drop term.
`timescale 1ns / 1ps
`default_nettype none
module rhsf_front #(
  parameter int MAX_PATTERN = rhsf_pkg::DEF_MAX_PATTERN,
  parameter int MAX_TEXT    = rhsf_pkg::DEF_MAX_TEXT,
  parameter int HASH_BITS   = rhsf_pkg::DEF_HASH_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_req_type,
  input  wire  [7:0]           in_char_value,
  input  wire                  in_last,
  input  wire                  q_full,
  output logic                 push,
  output rhsf_pkg::ctl_t       push_ctl,
  output logic [HASH_BITS-1:0] push_term
);
  import rhsf_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W  = $clog2(MAX_TEXT + 2);
  localparam int CW     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int PROD_W = HASH_BITS + 11;

  logic [LEN_W-1:0]     len_r, len_nxt, len_base;
  logic                 ready_r, ready_nxt;
  logic                 too_long_r, too_long_nxt;
  logic [HASH_BITS-1:0] pp_r, pp_nxt, pp_base;
  logic [CNT_W-1:0]     tc_r, tc_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;

  logic                 a_v_r;
  ctl_t                 a_ctl_r, ctl_nxt;
  logic [7:0]           a_char_r;
  logic                 a_sub_r, sub_nxt;
  logic [HASH_BITS-1:0] a_pp_r;

  logic [7:0]           window_mem [MAX_PATTERN];
  logic [7:0]           rd_data_r;
  logic                 mem_we;
  logic [PTR_W-1:0]     rd_addr;
  logic [LEN_W:0]       rd_full, wp_l, n_l;

  logic                 accept, is_text, counted;
  logic [CW-1:0]        tc_x, n_x;
  logic [31:0]          pos_diff;

  logic [HASH_BITS-1:0]    d_new, prod_h;
  logic signed [9:0]       od_s;
  logic signed [PROD_W-1:0] prod_s;

  assign accept  = in_valid && !in_stall;
  assign is_text = (op_t'(in_req_type) == OP_TEXT);
  assign counted = (tc_r <= CNT_W'(MAX_TEXT));
  assign tc_x    = CW'(tc_r);
  assign n_x     = CW'(len_r);
  assign pos_diff = 32'(tc_r) + 32'd1 - 32'(len_r);

  assign wp_l    = (LEN_W+1)'(wp_r);
  assign n_l     = (LEN_W+1)'(len_r);
  assign rd_full = (wp_l >= n_l) ? (wp_l - n_l) : (wp_l + (LEN_W+1)'(MAX_PATTERN) - n_l);
  assign rd_addr = rd_full[PTR_W-1:0];

  always_comb begin
    len_nxt      = len_r;
    ready_nxt    = ready_r;
    too_long_nxt = too_long_r;
    pp_nxt       = pp_r;
    tc_nxt       = tc_r;
    wp_nxt       = wp_r;
    len_base     = len_r;
    pp_base      = pp_r;
    sub_nxt      = 1'b0;
    mem_we       = 1'b0;
    ctl_nxt      = '0;
    ctl_nxt.op   = is_text ? OP_TEXT : OP_PATTERN;
    if (!is_text) begin
      ctl_nxt.restart = ready_r;
      if (ready_r) begin
        len_base     = '0;
        pp_base      = HASH_BITS'(1);
        too_long_nxt = 1'b0;
        ready_nxt    = 1'b0;
        tc_nxt       = '0;
        wp_nxt       = '0;
      end
      ctl_nxt.load = (len_base < LEN_W'(MAX_PATTERN));
      if (ctl_nxt.load) begin
        len_nxt = len_base + LEN_W'(1);
        pp_nxt  = (pp_base << 4) + (pp_base << 3) + (pp_base << 1);
      end else begin
        len_nxt      = len_base;
        pp_nxt       = pp_base;
        too_long_nxt = 1'b1;
      end
      if (in_last) begin
        ready_nxt = 1'b1;
      end
    end else begin
      ctl_nxt.fin = in_last;
      if (counted) begin
        tc_nxt = tc_r + CNT_W'(1);
        ctl_nxt.active = ready_r && !too_long_r && (tc_r < CNT_W'(MAX_TEXT));
        if (ctl_nxt.active) begin
          ctl_nxt.full = (tc_x + CW'(1) >= n_x);
          sub_nxt      = (tc_x >= n_x);
          mem_we       = 1'b1;
          wp_nxt       = (wp_r == PTR_W'(MAX_PATTERN - 1)) ? '0 : wp_r + PTR_W'(1);
        end
      end
      ctl_nxt.pos        = pos_diff[POS_W-1:0];
      ctl_nxt.err        = !ready_r || too_long_r || (tc_r >= CNT_W'(MAX_TEXT));
      ctl_nxt.err_status = (!ready_r || too_long_r) ? ST_NO_PATTERN : ST_TEXT_LONG;
      if (in_last) begin
        tc_nxt = '0;
        wp_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      ready_r    <= 1'b0;
      too_long_r <= 1'b0;
      pp_r       <= HASH_BITS'(1);
      tc_r       <= '0;
      wp_r       <= '0;
      a_v_r      <= 1'b0;
    end else begin
      if (accept) begin
        len_r      <= len_nxt;
        ready_r    <= ready_nxt;
        too_long_r <= too_long_nxt;
        pp_r       <= pp_nxt;
        tc_r       <= tc_nxt;
        wp_r       <= wp_nxt;
        a_v_r      <= 1'b1;
      end else if (push) begin
        a_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctl_r  <= ctl_nxt;
      a_char_r <= in_char_value;
      a_sub_r  <= sub_nxt;
      a_pp_r   <= pp_r;
    end
  end

  // read-before-write: a full-length window reads the slot being overwritten
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      window_mem[wp_r] <= in_char_value;
      rd_data_r        <= window_mem[rd_addr];
    end
  end

  assign d_new  = HASH_BITS'(a_char_r) - HASH_BITS'(CHAR_OFFSET);
  assign od_s   = signed'({2'b00, rd_data_r}) - signed'(10'(CHAR_OFFSET));
  assign prod_s = od_s * signed'({1'b0, a_pp_r});
  assign prod_h = prod_s[HASH_BITS-1:0];

  assign push_term = a_sub_r ? (d_new - prod_h) : d_new;
  assign push_ctl  = a_ctl_r;
  assign push      = a_v_r && !q_full;
  assign in_stall  = a_v_r && q_full;

endmodule
`default_nettype wire

[src/rhsf_queue.sv]
// Short request queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module rhsf_queue #(
  parameter int HASH_BITS = rhsf_pkg::DEF_HASH_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  rhsf_pkg::ctl_t       push_ctl,
  input  wire  [HASH_BITS-1:0] push_term,
  input  wire                  pop,
  output logic                 full,
  output logic                 head_valid,
  output rhsf_pkg::ctl_t       head_ctl,
  output logic [HASH_BITS-1:0] head_term
);
  import rhsf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  ctl_t                 ctl_mem  [Q_DEPTH];
  logic [HASH_BITS-1:0] term_mem [Q_DEPTH];
  logic [PTR_W-1:0]     wr_r, rd_r;
  logic [PTR_W:0]       cnt_r;

  assign full       = (cnt_r == (PTR_W+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_ctl   = ctl_mem[rd_r];
  assign head_term  = term_mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_r]  <= push_ctl;
      term_mem[wr_r] <= push_term;
    end
  end

endmodule
`default_nettype wire

[src/rhsf_back.sv]
// Back end: pattern hash, rolling window hash, match tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module rhsf_back #(
  parameter int HASH_BITS = rhsf_pkg::DEF_HASH_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  head_valid,
  input  rhsf_pkg::ctl_t       head_ctl,
  input  wire  [HASH_BITS-1:0] head_term,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           out_status,
  output logic [15:0]          out_position
);
  import rhsf_pkg::*;

  logic [HASH_BITS-1:0] ph_r, ph_nxt;
  logic [HASH_BITS-1:0] wh_r, wh_nxt, wh_new;
  logic                 mf_r, mf_nxt;
  logic [POS_W-1:0]     mpos_r, mpos_nxt;
  logic                 ov_r;
  logic [1:0]           ostat_r, res_status;
  logic [POS_W-1:0]     opos_r, res_pos;
  logic                 hit, done;

  assign pop    = head_valid && (!head_ctl.fin || !ov_r || !out_stall);
  assign done   = pop && (head_ctl.op == OP_TEXT) && head_ctl.fin;
  assign wh_new = (wh_r << 4) + (wh_r << 3) + (wh_r << 1) + head_term;

  always_comb begin
    ph_nxt   = ph_r;
    wh_nxt   = wh_r;
    mf_nxt   = mf_r;
    mpos_nxt = mpos_r;
    hit      = 1'b0;
    if (pop) begin
      unique case (head_ctl.op)
        OP_PATTERN: begin
          if (head_ctl.restart) begin
            ph_nxt   = head_term;
            wh_nxt   = '0;
            mf_nxt   = 1'b0;
            mpos_nxt = '0;
          end else if (head_ctl.load) begin
            ph_nxt = (ph_r << 4) + (ph_r << 3) + (ph_r << 1) + head_term;
          end
        end
        OP_TEXT: begin
          if (head_ctl.active) begin
            wh_nxt = wh_new;
            hit    = head_ctl.full && !mf_r && (wh_new == ph_r);
            if (hit) begin
              mf_nxt   = 1'b1;
              mpos_nxt = head_ctl.pos;
            end
          end
          if (head_ctl.fin) begin
            wh_nxt   = '0;
            mf_nxt   = 1'b0;
            mpos_nxt = '0;
          end
        end
        default: begin
          ph_nxt = ph_r;
        end
      endcase
    end
  end

  always_comb begin
    if (head_ctl.err) begin
      res_status = head_ctl.err_status;
    end else if (mf_r || hit) begin
      res_status = ST_FOUND;
    end else begin
      res_status = ST_NOT_FOUND;
    end
    if (res_status == ST_FOUND) begin
      res_pos = hit ? head_ctl.pos : mpos_r;
    end else begin
      res_pos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      wh_r   <= '0;
      mf_r   <= 1'b0;
      mpos_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      wh_r   <= wh_nxt;
      mf_r   <= mf_nxt;
      mpos_r <= mpos_nxt;
      if (done) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      ostat_r <= res_status;
      opos_r  <= res_pos;
    end
  end

  assign out_valid    = ov_r;
  assign out_status   = ostat_r;
  assign out_position = opos_r;

endmodule
`default_nettype wire
